### sv/ira_pkg.sv
package ira_pkg;

    // Command field of an input word
    typedef enum logic [1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // Inter-register ALU operations
    typedef enum logic [2:0] {
        OP_ADDR = 3'd0,
        OP_ADCR = 3'd1,
        OP_SUBR = 3'd2,
        OP_SBCR = 3'd3,
        OP_ANDR = 3'd4,
        OP_ORR  = 3'd5,
        OP_EORR = 3'd6,
        OP_CMPR = 3'd7
    } alu_op_t;

    // Register codes
    localparam logic [3:0] RC_D    = 4'd0;
    localparam logic [3:0] RC_X    = 4'd1;
    localparam logic [3:0] RC_Y    = 4'd2;
    localparam logic [3:0] RC_U    = 4'd3;
    localparam logic [3:0] RC_S    = 4'd4;
    localparam logic [3:0] RC_PC   = 4'd5;
    localparam logic [3:0] RC_W    = 4'd6;
    localparam logic [3:0] RC_V    = 4'd7;
    localparam logic [3:0] RC_A    = 4'd8;
    localparam logic [3:0] RC_B    = 4'd9;
    localparam logic [3:0] RC_CC   = 4'd10;
    localparam logic [3:0] RC_DP   = 4'd11;
    localparam logic [3:0] RC_Z0   = 4'd12;
    localparam logic [3:0] RC_Z1   = 4'd13;
    localparam logic [3:0] RC_E    = 4'd14;
    localparam logic [3:0] RC_F    = 4'd15;

    localparam logic [15:0] BYTE_FILL = 16'hFF00;

    // Condition code bit positions
    localparam int unsigned CC_N = 3;
    localparam int unsigned CC_Z = 2;
    localparam int unsigned CC_V = 1;
    localparam int unsigned CC_C = 0;

    typedef struct packed {
        logic [7:0]  acc_a;
        logic [7:0]  acc_b;
        logic [7:0]  acc_e;
        logic [7:0]  acc_f;
        logic [15:0] index_x;
        logic [15:0] index_y;
        logic [15:0] user_stack;
        logic [15:0] system_stack;
        logic [15:0] program_counter;
        logic [15:0] value_reg;
        logic [7:0]  flags;
        logic [7:0]  direct_page;
    } regfile_t;

endpackage

### sv/inter_register_alu_core.sv
// Channel | Handshake       | Fields                                                 | Dir
// --------+-----------------+--------------------------------------------------------+----
// input   | s_valid s_ready | s_command s_alu_op s_src_code s_dst_code s_write_value | in
// result  | m_valid m_ready | m_result_value m_condition_codes                       | out
//
// One word per cycle sustained while m_ready stays high; an accepted word waits in the
// input register until the result slot frees, then enters the result register. The
// register file updates as a word leaves the input register, so the next word always
// sees the previous word's writes. Reset (aresetn low, synchronous) clears both stage
// valids and every architectural register. With m_ready low the result holds; one more
// word is still taken into the input register before s_ready drops.
module inter_register_alu_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [2:0]  s_alu_op,
    input  logic [3:0]  s_src_code,
    input  logic [3:0]  s_dst_code,
    input  logic [15:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_value,
    output logic [7:0]  m_condition_codes
);
    import ira_pkg::*;

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_cmd_reg;
    logic [2:0]  in_op_reg;
    logic [3:0]  in_src_reg;
    logic [3:0]  in_dst_reg;
    logic [15:0] in_wval_reg;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_value_reg;
    logic [7:0]  out_cc_reg;

    // Architectural registers
    regfile_t rf_reg, rf_next;

    logic        advance;
    logic [15:0] src_val, dst_val;
    logic [15:0] alu_res;
    logic [15:0] res_value;
    logic [15:0] opnd_b;
    logic [16:0] sum;
    logic        cin;
    logic        is_sub;
    logic        is_logic;
    logic [7:0]  cc_alu;
    logic        wr_en;
    logic [3:0]  wr_code;
    logic [15:0] wr_data;

    // Read a register by code; 8-bit registers fill the high byte with ones.
    function automatic logic [15:0] read_reg(input regfile_t rf, input logic [3:0] code);
        logic [15:0] v;
        begin
            case (code)
                RC_D:    v = {rf.acc_a, rf.acc_b};
                RC_X:    v = rf.index_x;
                RC_Y:    v = rf.index_y;
                RC_U:    v = rf.user_stack;
                RC_S:    v = rf.system_stack;
                RC_PC:   v = rf.program_counter;
                RC_W:    v = {rf.acc_e, rf.acc_f};
                RC_V:    v = rf.value_reg;
                RC_A:    v = BYTE_FILL | {8'h00, rf.acc_a};
                RC_B:    v = BYTE_FILL | {8'h00, rf.acc_b};
                RC_CC:   v = BYTE_FILL | {8'h00, rf.flags};
                RC_DP:   v = BYTE_FILL | {8'h00, rf.direct_page};
                RC_E:    v = BYTE_FILL | {8'h00, rf.acc_e};
                RC_F:    v = BYTE_FILL | {8'h00, rf.acc_f};
                default: v = 16'h0000;
            endcase
            return v;
        end
    endfunction

    // Pipeline control: the input word moves on whenever the result slot frees.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;

    assign src_val = read_reg(rf_reg, in_src_reg);
    assign dst_val = read_reg(rf_reg, in_dst_reg);

    // Adder shared by all arithmetic ops; subtract adds the complement.
    always_comb begin
        case (alu_op_t'(in_op_reg))
            OP_ADDR: begin is_sub = 1'b0; cin = 1'b0;                  end
            OP_ADCR: begin is_sub = 1'b0; cin = rf_reg.flags[CC_C];    end
            OP_SUBR: begin is_sub = 1'b1; cin = 1'b1;                  end
            OP_SBCR: begin is_sub = 1'b1; cin = !rf_reg.flags[CC_C];   end
            OP_CMPR: begin is_sub = 1'b1; cin = 1'b1;                  end
            default: begin is_sub = 1'b0; cin = 1'b0;                  end
        endcase
        opnd_b = is_sub ? ~src_val : src_val;
        sum    = {1'b0, dst_val} + {1'b0, opnd_b} + {16'h0000, cin};
    end

    always_comb begin
        is_logic = 1'b0;
        case (alu_op_t'(in_op_reg))
            OP_ANDR: begin alu_res = dst_val & src_val; is_logic = 1'b1; end
            OP_ORR:  begin alu_res = dst_val | src_val; is_logic = 1'b1; end
            OP_EORR: begin alu_res = dst_val ^ src_val; is_logic = 1'b1; end
            default: alu_res = sum[15:0];
        endcase

        cc_alu       = rf_reg.flags;
        cc_alu[CC_N] = alu_res[15];
        cc_alu[CC_Z] = (alu_res == 16'h0000);
        if (is_logic) begin
            cc_alu[CC_V] = 1'b0;
        end else begin
            cc_alu[CC_V] = ((dst_val[15] ^ alu_res[15]) & (opnd_b[15] ^ alu_res[15]));
            cc_alu[CC_C] = is_sub ? !sum[16] : sum[16];
        end
    end

    // Decode the command into at most one register write, the ALU flags and a result value.
    always_comb begin
        rf_next   = rf_reg;
        wr_en     = 1'b0;
        wr_code   = in_dst_reg;
        wr_data   = in_wval_reg;
        res_value = 16'h0000;

        case (cmd_t'(in_cmd_reg))
            CMD_EXEC: begin
                res_value     = alu_res;
                rf_next.flags = cc_alu;
                wr_en         = (alu_op_t'(in_op_reg) != OP_CMPR);
                // 8-bit destinations keep the low byte; the write below truncates
                wr_data       = alu_res;
            end
            CMD_WRITE: begin
                wr_en = 1'b1;
            end
            CMD_READ: begin
                res_value = dst_val;
            end
            default: ;
        endcase

        if (wr_en) begin
            case (wr_code)
                RC_D:    {rf_next.acc_a, rf_next.acc_b} = wr_data;
                RC_X:    rf_next.index_x         = wr_data;
                RC_Y:    rf_next.index_y         = wr_data;
                RC_U:    rf_next.user_stack      = wr_data;
                RC_S:    rf_next.system_stack    = wr_data;
                RC_PC:   rf_next.program_counter = wr_data;
                RC_W:    {rf_next.acc_e, rf_next.acc_f} = wr_data;
                RC_V:    rf_next.value_reg       = wr_data;
                RC_A:    rf_next.acc_a           = wr_data[7:0];
                RC_B:    rf_next.acc_b           = wr_data[7:0];
                RC_CC:   rf_next.flags           = wr_data[7:0];
                RC_DP:   rf_next.direct_page     = wr_data[7:0];
                RC_E:    rf_next.acc_e           = wr_data[7:0];
                RC_F:    rf_next.acc_f           = wr_data[7:0];
                default: ; // zero register: drop the write
            endcase
        end
    end

    // Valid flags of both stages
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_reg        <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // commit architectural state only when the word moves on
            if (advance) begin
                rf_reg <= rf_next;
            end
        end
    end

    // Payload registers: the input side captures on accept, the result side on advance; both hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_op_reg   <= s_alu_op;
            in_src_reg  <= s_src_code;
            in_dst_reg  <= s_dst_code;
            in_wval_reg <= s_write_value;
        end
        if (advance) begin
            out_value_reg <= res_value;
            out_cc_reg    <= rf_next.flags;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_value    = out_value_reg;
    assign m_condition_codes = out_cc_reg;

endmodule

### sv/ira_checker.sv
module ira_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_result_value,
    input logic [7:0]  m_condition_codes
);

    // Stalled result holds its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
                               && $stable(m_condition_codes))
        else $error("result word changed while stalled");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Input backpressure only when the result side is stalled
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while result side is free");

    // After each accept m_valid must come high, showing this word or an older stalled one
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("no result two cycles after accept");

endmodule

bind inter_register_alu_core ira_checker u_ira_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_result_value    (m_result_value),
    .m_condition_codes (m_condition_codes)
);

### tb/sv/alu_result_checker.sv
`timescale 1ns / 1ps
module alu_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [2:0]  s_alu_op,
    input  logic [3:0]  s_src_code,
    input  logic [3:0]  s_dst_code,
    input  logic [15:0] s_write_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_result_value,
    input  logic [7:0]  m_condition_codes,
    output int          mismatch_count,
    output int          results_checked,
    output int          outstanding
);
    import ira_pkg::*;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  cc;
    } alu_result_t;

    regfile_t    arch;
    alu_result_t expected_results[$];

    initial begin
        mismatch_count  = 0;
        results_checked = 0;
        outstanding     = 0;
    end

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
        mismatch_count++;
    endtask

    function automatic logic [15:0] read_reg(input logic [3:0] code);
        case (code)
            RC_D:    return {arch.acc_a, arch.acc_b};
            RC_X:    return arch.index_x;
            RC_Y:    return arch.index_y;
            RC_U:    return arch.user_stack;
            RC_S:    return arch.system_stack;
            RC_PC:   return arch.program_counter;
            RC_W:    return {arch.acc_e, arch.acc_f};
            RC_V:    return arch.value_reg;
            RC_A:    return BYTE_FILL | {8'h00, arch.acc_a};
            RC_B:    return BYTE_FILL | {8'h00, arch.acc_b};
            RC_CC:   return BYTE_FILL | {8'h00, arch.flags};
            RC_DP:   return BYTE_FILL | {8'h00, arch.direct_page};
            RC_E:    return BYTE_FILL | {8'h00, arch.acc_e};
            RC_F:    return BYTE_FILL | {8'h00, arch.acc_f};
            default: return 16'h0000;
        endcase
    endfunction

    // Byte registers keep the low byte; the zero register drops the write.
    function automatic void write_reg(input logic [3:0] code, input logic [15:0] value);
        case (code)
            RC_D:    {arch.acc_a, arch.acc_b} = value;
            RC_X:    arch.index_x = value;
            RC_Y:    arch.index_y = value;
            RC_U:    arch.user_stack = value;
            RC_S:    arch.system_stack = value;
            RC_PC:   arch.program_counter = value;
            RC_W:    {arch.acc_e, arch.acc_f} = value;
            RC_V:    arch.value_reg = value;
            RC_A:    arch.acc_a = value[7:0];
            RC_B:    arch.acc_b = value[7:0];
            RC_CC:   arch.flags = value[7:0];
            RC_DP:   arch.direct_page = value[7:0];
            RC_E:    arch.acc_e = value[7:0];
            RC_F:    arch.acc_f = value[7:0];
            default: ;
        endcase
    endfunction

    // Subtract adds the complement plus the inverted borrow; C is the borrow.
    function automatic logic [15:0] add_sub(input logic [15:0] a, input logic [15:0] b,
                                            input logic c_flag, input logic subtract);
        logic [15:0] operand;
        logic [16:0] full;
        logic [15:0] sum;
        operand = subtract ? ~b : b;
        full = {1'b0, a} + {1'b0, operand} + {16'h0000, subtract ? ~c_flag : c_flag};
        sum = full[15:0];
        arch.flags[CC_N] = sum[15];
        arch.flags[CC_Z] = (sum == 16'h0000);
        arch.flags[CC_V] = (a[15] ^ sum[15]) & (operand[15] ^ sum[15]);
        arch.flags[CC_C] = subtract ? ~full[16] : full[16];
        return sum;
    endfunction

    function automatic void set_logic_flags(input logic [15:0] r);
        arch.flags[CC_N] = r[15];
        arch.flags[CC_Z] = (r == 16'h0000);
        arch.flags[CC_V] = 1'b0;
    endfunction

    function automatic alu_result_t execute_word(input logic [1:0] cmd,
                                                 input logic [2:0] op,
                                                 input logic [3:0] src,
                                                 input logic [3:0] dst,
                                                 input logic [15:0] value);
        logic [15:0] src_val;
        logic [15:0] dst_val;
        logic [15:0] sum;
        logic        carry;
        alu_result_t r;
        sum = 16'h0000;
        case (cmd)
            CMD_EXEC: begin
                src_val = read_reg(src);
                dst_val = read_reg(dst);
                carry   = arch.flags[CC_C];
                case (op)
                    OP_ADDR: sum = add_sub(dst_val, src_val, 1'b0, 1'b0);
                    OP_ADCR: sum = add_sub(dst_val, src_val, carry, 1'b0);
                    OP_SUBR: sum = add_sub(dst_val, src_val, 1'b0, 1'b1);
                    OP_SBCR: sum = add_sub(dst_val, src_val, carry, 1'b1);
                    OP_ANDR: begin
                        sum = dst_val & src_val;
                        set_logic_flags(sum);
                    end
                    OP_ORR: begin
                        sum = dst_val | src_val;
                        set_logic_flags(sum);
                    end
                    OP_EORR: begin
                        sum = dst_val ^ src_val;
                        set_logic_flags(sum);
                    end
                    default: sum = add_sub(dst_val, src_val, 1'b0, 1'b1);
                endcase
                // A flags destination overwrites the ALU flags just set.
                if (op != OP_CMPR) write_reg(dst, sum);
            end
            CMD_WRITE: write_reg(dst, value);
            CMD_READ:  sum = read_reg(dst);
            default:   ;
        endcase
        r.value = sum;
        r.cc    = arch.flags;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        alu_result_t want;
        if (!aresetn) begin
            arch = '0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result_value", m_result_value, 16'h0000);
                end else begin
                    want = expected_results.pop_front();
                    if (m_result_value !== want.value)
                        report_mismatch("result_value", m_result_value, want.value);
                    if (m_condition_codes !== want.cc)
                        report_mismatch("condition_codes", {8'h00, m_condition_codes},
                                        {8'h00, want.cc});
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(execute_word(s_command, s_alu_op, s_src_code,
                                                        s_dst_code, s_write_value));
        end
        outstanding <= expected_results.size();
    end

endmodule

### tb/sv/inter_register_alu_core_test.sv
`timescale 1ns / 1ps
module inter_register_alu_core_test;
    import ira_pkg::*;

    // Command code 3 is not decoded by the block; it must leave all state alone.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Timeout guard: a correct run ends well before CYCLE_LIMIT.
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_WORDS    = 197;
    localparam int PRESSURE_WORDS = 40;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic [1:0]  s_command     = CMD_EXEC;
    logic [2:0]  s_alu_op      = OP_ADDR;
    logic [3:0]  s_src_code    = RC_D;
    logic [3:0]  s_dst_code    = RC_D;
    logic [15:0] s_write_value = 16'h0000;
    logic        m_ready       = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [15:0] m_result_value;
    wire  [7:0]  m_condition_codes;

    int   mismatches;
    int   results_checked;
    int   outstanding;
    int   words_sent   = 0;
    int   cycle_count  = 0;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    logic hold_results = 1'b0;

    inter_register_alu_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_alu_op          (s_alu_op),
        .s_src_code        (s_src_code),
        .s_dst_code        (s_dst_code),
        .s_write_value     (s_write_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_value    (m_result_value),
        .m_condition_codes (m_condition_codes)
    );

    alu_result_checker result_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_alu_op          (s_alu_op),
        .s_src_code        (s_src_code),
        .s_dst_code        (s_dst_code),
        .s_write_value     (s_write_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_value    (m_result_value),
        .m_condition_codes (m_condition_codes),
        .mismatch_count    (mismatches),
        .results_checked   (results_checked),
        .outstanding       (outstanding)
    );

    // 10 ns clock, first rising edge at 5 ns.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, outstanding);
            $display("inter_register_alu_core test failed");
            $finish;
        end
    end

    // Result side: stall at random per the current phase. On request, hold
    // m_ready low for a long stretch so the pipe fills and s_ready drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_results) begin
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_results <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one word, with random idle cycles first, and hold it until taken.
    // Leave valid high on return so back-to-back words need no extra edge.
    task automatic send_word(input logic [1:0] cmd, input logic [2:0] op,
                             input logic [3:0] src, input logic [3:0] dst,
                             input logic [15:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_alu_op      <= op;
        s_src_code    <= src;
        s_dst_code    <= dst;
        s_write_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // Mostly ALU ops, then writes and reads; a few undecoded commands.
    // Bias write data toward sign and carry boundaries.
    task automatic send_random_word;
        int          pick;
        logic [1:0]  cmd;
        logic [15:0] value;
        pick = $urandom_range(99);
        if (pick < 50)      cmd = CMD_EXEC;
        else if (pick < 75) cmd = CMD_WRITE;
        else if (pick < 95) cmd = CMD_READ;
        else                cmd = CMD_UNUSED;
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(6))
                0:       value = 16'h0000;
                1:       value = 16'hFFFF;
                2:       value = 16'h8000;
                3:       value = 16'h7FFF;
                4:       value = 16'h0001;
                5:       value = 16'h00FF;
                default: value = 16'hFF00;
            endcase
        end else begin
            value = 16'($urandom);
        end
        send_word(cmd, 3'($urandom_range(7)), 4'($urandom_range(15)),
                  4'($urandom_range(15)), value);
    endtask

    // Drop valid and wait for every predicted result to come back.
    task automatic wait_for_results;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct <= receiver_stall;
        repeat (PHASE_WORDS) send_random_word();
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: reset values, every op, flag corners and the
        // register codes with special write or read behavior.
        send_word(CMD_READ,   OP_ADDR, RC_D,  RC_D,  16'hFFFF);
        send_word(CMD_WRITE,  OP_ADDR, RC_D,  RC_X,  16'hFFFF);
        send_word(CMD_WRITE,  OP_ADDR, RC_D,  RC_D,  16'h8000);
        // negative plus negative: overflow and carry
        send_word(CMD_EXEC,   OP_ADDR, RC_X,  RC_D,  16'h0000);
        send_word(CMD_EXEC,   OP_ADCR, RC_Z0, RC_Y,  16'h0000);
        send_word(CMD_EXEC,   OP_SUBR, RC_X,  RC_Y,  16'h0000);
        send_word(CMD_EXEC,   OP_SBCR, RC_Y,  RC_U,  16'h0000);
        send_word(CMD_WRITE,  OP_ADDR, RC_D,  RC_A,  16'h1234);
        // byte register as source reads with the high byte filled
        send_word(CMD_EXEC,   OP_ANDR, RC_A,  RC_W,  16'h0000);
        send_word(CMD_EXEC,   OP_ORR,  RC_A,  RC_W,  16'h0000);
        send_word(CMD_EXEC,   OP_EORR, RC_W,  RC_W,  16'h0000);
        send_word(CMD_EXEC,   OP_CMPR, RC_X,  RC_X,  16'h0000);
        // flags as destination: the truncated sum replaces the new flags
        send_word(CMD_EXEC,   OP_ADDR, RC_DP, RC_CC, 16'h0000);
        send_word(CMD_WRITE,  OP_ADDR, RC_D,  RC_CC, 16'h00FF);
        // zero register as destination: flags update, sum is dropped
        send_word(CMD_EXEC,   OP_ADDR, RC_X,  RC_Z1, 16'h0000);
        send_word(CMD_WRITE,  OP_ADDR, RC_D,  RC_Z0, 16'hABCD);
        send_word(CMD_READ,   OP_ADDR, RC_D,  RC_Z0, 16'h0000);
        send_word(CMD_WRITE,  OP_ADDR, RC_D,  RC_E,  16'hFFFF);
        send_word(CMD_WRITE,  OP_ADDR, RC_D,  RC_F,  16'h0000);
        send_word(CMD_READ,   OP_ADDR, RC_D,  RC_E,  16'h0000);
        // byte destination keeps only the low byte
        send_word(CMD_EXEC,   OP_ADDR, RC_E,  RC_F,  16'h0000);
        send_word(CMD_READ,   OP_ADDR, RC_D,  RC_F,  16'h0000);
        send_word(CMD_UNUSED, OP_CMPR, RC_F,  RC_F,  16'hFFFF);
        send_word(CMD_READ,   OP_ADDR, RC_D,  RC_CC, 16'h0000);
        wait_for_results();

        // Random words under each idle/stall mix.
        run_phase(0, 0);
        run_phase(57, 0);
        run_phase(0, 57);
        run_phase(35, 35);

        // Back-pressure: freeze the result side while words keep coming.
        idle_pct  = 0;
        stall_pct <= 0;
        hold_results <= 1'b1;
        repeat (PRESSURE_WORDS) send_random_word();
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Drove %0d words: directed corners, four idle/stall mixes, long result hold.",
                 words_sent);
        $display("Checked %0d results in %0d cycles, %0d mismatches.",
                 results_checked, cycle_count, mismatches);
        if (mismatches == 0) begin
            $display("inter_register_alu_core test passed");
        end else begin
            $display("inter_register_alu_core test failed");
        end
        $finish;
    end

endmodule

### files.f
sv/ira_pkg.sv
sv/inter_register_alu_core.sv
sv/ira_checker.sv
tb/sv/alu_result_checker.sv
tb/sv/inter_register_alu_core_test.sv
